FILE: design/fird2_pkg.sv
// Package for the decimate-by-two FIR filter.
// Holds shared widths, defaults and the control and status types of the MAC unit.
// No dependencies.
package fird2_pkg;

    localparam int TAPS_DEF = 64;
    localparam int SMP_W    = 16;
    localparam int PROD_W   = 2 * SMP_W;
    localparam int ACC_W    = 40;

    typedef struct packed {
        logic clear;
        logic en;
    } t_mac_ctrl;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] acc;
    } t_mac_stat;

endpackage

FILE: design/fird2_mac.sv
// Shared multiply-accumulate unit of the decimate-by-two FIR filter.
// One registered 16x16 product feeding a 40-bit accumulator; uses fird2_pkg.
module fird2_mac
    import fird2_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctrl               i_ctrl,
    input  logic signed [SMP_W-1:0] i_x,
    input  logic signed [SMP_W-1:0] i_c,
    output t_mac_stat               o_stat
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (r_prod_vld) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_c;
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctrl.en;
            r_acc      <= n_acc;
        end
    end

    assign o_stat.busy = r_prod_vld;
    assign o_stat.acc  = r_acc;

endmodule

FILE: design/fir_decimate_by_two.sv
// Top level of the decimate-by-two FIR filter with a circular delay line.
// Holds the delay and coefficient memories and the sequencer; uses fird2_pkg and fird2_mac.
//
// Channel   Direction  Handshake                          Payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata: sample, coef_index, coef_value
//                                                          tuser: opcode
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata: filtered; tuser: saturated
//
// A coefficient item or a sample item that gives no result leaves the block ready for the next item.
// A sample item that gives a result is worked one tap per cycle through the single
// multiply-accumulate unit, then pipeline drain and rounding, before the next item is taken.
// Reset clears the valid bits of both memories, so all entries read as zero.
// A result waiting on a stalled output holds the sequencer before rounding only.
module fir_decimate_by_two
    import fird2_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Bits from the lowest up: sample[15:0], coef_index[21:16], coef_value[37:22], zero pad.
    input  logic [39:0] i_s_axis_tdata,
    // Bits from the lowest up: opcode.
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Bits from the lowest up: filtered[15:0].
    output logic [15:0] o_m_axis_tdata,
    // Bits from the lowest up: saturated.
    output logic        o_m_axis_tuser
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
    localparam int QW = ACC_W - 15;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic                    in_op;
    logic signed [SMP_W-1:0] in_sample;
    logic [5:0]              in_cidx;
    logic signed [SMP_W-1:0] in_cval;
    logic                    acc_in;
    logic                    smp_we;
    logic                    cf_we;
    logic [AW-1:0]           n_wp;

    logic [1:0]              r_state;
    logic [AW-1:0]           r_wp;
    logic [AW-1:0]           r_rp;
    logic [AW-1:0]           r_k;
    logic                    r_phase;
    logic                    r_rd_vld;
    logic [TAPS-1:0]         r_dl_vld;
    logic [TAPS-1:0]         r_cf_vld;

    logic signed [SMP_W-1:0] dl_mem [TAPS];
    logic signed [SMP_W-1:0] cf_mem [TAPS];
    logic signed [SMP_W-1:0] r_x_rd;
    logic signed [SMP_W-1:0] r_c_rd;
    logic                    r_x_ok;
    logic                    r_c_ok;

    t_mac_ctrl               mac_ctrl;
    t_mac_stat               mac_stat;
    logic signed [SMP_W-1:0] mac_x;
    logic signed [SMP_W-1:0] mac_c;

    logic signed [ACC_W-1:0] rnd;
    logic signed [QW-1:0]    q;
    logic signed [SMP_W-1:0] q_sat;
    logic                    q_clip;
    logic                    out_free;

    logic                    r_out_vld;
    logic [SMP_W-1:0]        r_out_data;
    logic                    r_out_sat;

    assign in_op     = i_s_axis_tuser;
    assign in_sample = i_s_axis_tdata[15:0];
    assign in_cidx   = i_s_axis_tdata[21:16];
    assign in_cval   = i_s_axis_tdata[37:22];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc_in = i_s_axis_tvalid && o_s_axis_tready;
    assign smp_we = acc_in && !in_op;
    assign cf_we  = acc_in && in_op && (32'(in_cidx) < TAPS);
    assign n_wp   = (r_wp == '0) ? LAST : r_wp - 1'b1;

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            dl_mem[n_wp] <= in_sample;
        end
        r_x_rd <= dl_mem[r_rp];
        r_x_ok <= r_dl_vld[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (cf_we) begin
            cf_mem[AW'(in_cidx)] <= in_cval;
        end
        r_c_rd <= cf_mem[r_k];
        r_c_ok <= r_cf_vld[r_k];
    end

    assign mac_x          = r_x_ok ? r_x_rd : '0;
    assign mac_c          = r_c_ok ? r_c_rd : '0;
    assign mac_ctrl.clear = (r_state == S_IDLE);
    assign mac_ctrl.en    = r_rd_vld;

    fird2_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_x     (mac_x),
        .i_c     (mac_c),
        .o_stat  (mac_stat)
    );

    always_comb begin
        rnd    = mac_stat.acc + ACC_W'(16384);
        q      = QW'(rnd >>> 15);
        q_clip = 1'b0;
        q_sat  = SMP_W'(q);
        if (q > QW'(32767)) begin
            q_sat  = 16'sh7fff;
            q_clip = 1'b1;
        end else if (q < -QW'(32768)) begin
            q_sat  = 16'sh8000;
            q_clip = 1'b1;
        end
    end

    assign out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_k       <= '0;
            r_phase   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_dl_vld  <= '0;
            r_cf_vld  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (cf_we) begin
                r_cf_vld[AW'(in_cidx)] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (smp_we) begin
                        r_wp             <= n_wp;
                        r_rp             <= n_wp;
                        r_k              <= '0;
                        r_dl_vld[n_wp]   <= 1'b1;
                        r_phase          <= !r_phase;
                        if (r_phase) begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_rd_vld <= 1'b1;
                    r_rp     <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
                    r_k      <= r_k + 1'b1;
                    if (r_k == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !mac_stat.busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_data <= q_sat;
            r_out_sat  <= q_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

endmodule
